/* design/annulus_zone_classify_and_sigma_core_assert.svh */
// assertion macros for the annulus zone classifier
// used by annulus_zone_classify_and_sigma_core, no other dependencies
`ifndef ANNULUS_ZONE_CLASSIFY_AND_SIGMA_CORE_ASSERT_SVH
`define ANNULUS_ZONE_CLASSIFY_AND_SIGMA_CORE_ASSERT_SVH

// same-cycle implication
`define AZCS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AZCS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/azcs_pkg.sv */
// shared constants and types of the annulus zone classifier
// no dependencies
package azcs_pkg;

  localparam int unsigned CELL_INDEX_BITS_DEF = 24;
  localparam int unsigned SIGMA_FRAC_BITS_DEF = 16;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned AXIS_FRAC  = 14;
  localparam int unsigned RAD_W      = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // internal widths
  localparam int unsigned PROD1_W = COORD_W + AXIS_W;   // axis * point
  localparam int unsigned SUM1_W  = PROD1_W + 2;        // three products
  localparam int unsigned DOT_W   = 36;                 // |dot| < 3 * 2^32
  localparam int unsigned PROD2_W = DOT_W + AXIS_W;     // dot * axis
  localparam int unsigned TRK_W   = PROD2_W - AXIS_FRAC;
  localparam int unsigned DIFF_W  = 40;
  localparam int unsigned MAG_W   = 31;                 // |d| below 2^31
  localparam int unsigned SQ_W    = 2 * MAG_W;
  localparam int unsigned SUM2_W  = 64;
  localparam int unsigned DIST_W  = SUM2_W / 2;
  localparam int unsigned SQRT_STAGES = DIST_W;

  localparam logic signed [AXIS_W-1:0] AXIS_Z_RST  = 16'sd16384;
  localparam logic [RAD_W-1:0]         RAD_OUT_RST = 31'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_X   = 3'd0,
    REG_AXIS_Y   = 3'd1,
    REG_AXIS_Z   = 3'd2,
    REG_CENTRE_X = 3'd3,
    REG_CENTRE_Y = 3'd4,
    REG_CENTRE_Z = 3'd5,
    REG_RAD_IN   = 3'd6,
    REG_RAD_OUT  = 3'd7
  } cfg_reg_e;

endpackage

/* design/annulus_zone_classify_and_sigma_core.sv */
// annulus zone classifier: axis projection, radial distance, ring test, sigma
// depends on azcs_pkg and annulus_zone_classify_and_sigma_core_assert.svh
//
//   channel | direction | signals                                   | transfer
//   --------+-----------+-------------------------------------------+----------------------
//   cfg     | in        | cfg_we_i cfg_index_i cfg_data_i           | cfg_we_i high
//   in      | in        | cell_index_i point_x_i point_y_i point_z_i| in_valid_i & in_ready_o
//   out     | out       | zone_cell_index_o sigma_o                 | out_valid_o & out_ready_i
//
// one point enters per cycle while the output register is not stalled
// the pipeline depth is set by the 32-stage bit-per-stage square root and the
// (SIGMA_FRAC_BITS + 1)-stage restoring divider
// reset (rst_ni low) empties the pipeline and loads the register defaults
// a stall at the output register freezes every stage; nothing is lost or repeated
// points outside the ring leave the pipeline without an output transfer
`include "annulus_zone_classify_and_sigma_core_assert.svh"

module annulus_zone_classify_and_sigma_core #(
  parameter int unsigned CELL_INDEX_BITS = azcs_pkg::CELL_INDEX_BITS_DEF,
  parameter int unsigned SIGMA_FRAC_BITS = azcs_pkg::SIGMA_FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [azcs_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [azcs_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [CELL_INDEX_BITS-1:0]             cell_index_i,
  input  logic signed [azcs_pkg::COORD_W-1:0]    point_x_i,
  input  logic signed [azcs_pkg::COORD_W-1:0]    point_y_i,
  input  logic signed [azcs_pkg::COORD_W-1:0]    point_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [CELL_INDEX_BITS-1:0]             zone_cell_index_o,
  output logic [SIGMA_FRAC_BITS:0]               sigma_o
);
  import azcs_pkg::*;

  localparam int unsigned SW = SIGMA_FRAC_BITS + 1;   // sigma width
  localparam int unsigned DIV_STAGES = SW;
  localparam logic [SW-1:0] SIGMA_ONE = {1'b1, {SIGMA_FRAC_BITS{1'b0}}};

  // configuration registers
  logic signed [AXIS_W-1:0]  axis_x_q, axis_y_q, axis_z_q;
  logic signed [COORD_W-1:0] centre_x_q, centre_y_q, centre_z_q;
  logic [RAD_W-1:0]          rad_in_q, rad_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_x_q   <= '0;
      axis_y_q   <= '0;
      axis_z_q   <= AXIS_Z_RST;
      centre_x_q <= '0;
      centre_y_q <= '0;
      centre_z_q <= '0;
      rad_in_q   <= '0;
      rad_out_q  <= RAD_OUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_AXIS_X:   axis_x_q   <= cfg_data_i[AXIS_W-1:0];
        REG_AXIS_Y:   axis_y_q   <= cfg_data_i[AXIS_W-1:0];
        REG_AXIS_Z:   axis_z_q   <= cfg_data_i[AXIS_W-1:0];
        REG_CENTRE_X: centre_x_q <= cfg_data_i[COORD_W-1:0];
        REG_CENTRE_Y: centre_y_q <= cfg_data_i[COORD_W-1:0];
        REG_CENTRE_Z: centre_z_q <= cfg_data_i[COORD_W-1:0];
        REG_RAD_IN:   rad_in_q   <= cfg_data_i[RAD_W-1:0];
        REG_RAD_OUT:  rad_out_q  <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the whole pipeline moves unless the output holds a result
  // that the consumer has not taken
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // stage 1: axis * point products
  logic                       s1_vld_q;
  logic [CELL_INDEX_BITS-1:0] s1_cell_q;
  logic signed [COORD_W-1:0]  s1_px_q, s1_py_q, s1_pz_q;
  logic signed [PROD1_W-1:0]  s1_mx_q, s1_my_q, s1_mz_q;

  // stage 2: dot product truncated to coordinate scale
  logic                       s2_vld_q;
  logic [CELL_INDEX_BITS-1:0] s2_cell_q;
  logic signed [COORD_W-1:0]  s2_px_q, s2_py_q, s2_pz_q;
  logic signed [DOT_W-1:0]    s2_dot_q;
  logic signed [SUM1_W-1:0]   s2_sum;
  logic signed [SUM1_W-1:0]   s2_dot_full;

  // stage 3: dot * axis products
  logic                       s3_vld_q;
  logic [CELL_INDEX_BITS-1:0] s3_cell_q;
  logic signed [COORD_W-1:0]  s3_px_q, s3_py_q, s3_pz_q;
  logic signed [PROD2_W-1:0]  s3_mx_q, s3_my_q, s3_mz_q;

  // stage 4: projected difference to the centre
  logic                       s4_vld_q;
  logic [CELL_INDEX_BITS-1:0] s4_cell_q;
  logic signed [DIFF_W-1:0]   s4_dx_q, s4_dy_q, s4_dz_q;
  logic signed [DIFF_W-1:0]   s4_dx_d, s4_dy_d, s4_dz_d;

  // stage 5: squares and far-point flag
  logic                       s5_vld_q;
  logic [CELL_INDEX_BITS-1:0] s5_cell_q;
  logic                       s5_far_q;
  logic [SQ_W-1:0]            s5_qx_q, s5_qy_q, s5_qz_q;
  logic [DIFF_W-1:0]          s5_ax, s5_ay, s5_az;

  // truncation toward zero of a signed product by the axis fraction bits
  function automatic logic signed [TRK_W-1:0] trunc_axis(logic signed [PROD2_W-1:0] v);
    logic signed [PROD2_W-1:0] r;
    r = (v < 0) ? -((-v) >>> AXIS_FRAC) : (v >>> AXIS_FRAC);
    return r[TRK_W-1:0];
  endfunction

  always_comb begin
    s2_sum = SUM1_W'(s1_mx_q) + SUM1_W'(s1_my_q) + SUM1_W'(s1_mz_q);
    s2_dot_full = (s2_sum < 0) ? -((-s2_sum) >>> AXIS_FRAC) : (s2_sum >>> AXIS_FRAC);

    s4_dx_d = DIFF_W'(s3_px_q) - DIFF_W'(trunc_axis(s3_mx_q)) - DIFF_W'(centre_x_q);
    s4_dy_d = DIFF_W'(s3_py_q) - DIFF_W'(trunc_axis(s3_my_q)) - DIFF_W'(centre_y_q);
    s4_dz_d = DIFF_W'(s3_pz_q) - DIFF_W'(trunc_axis(s3_mz_q)) - DIFF_W'(centre_z_q);

    s5_ax = (s4_dx_q < 0) ? DIFF_W'(-s4_dx_q) : DIFF_W'(s4_dx_q);
    s5_ay = (s4_dy_q < 0) ? DIFF_W'(-s4_dy_q) : DIFF_W'(s4_dy_q);
    s5_az = (s4_dz_q < 0) ? DIFF_W'(-s4_dz_q) : DIFF_W'(s4_dz_q);
  end

  // square root pipeline: entry 0 is the sum of squares, one result bit per stage
  logic                       sq_vld_q  [0:SQRT_STAGES];
  logic [CELL_INDEX_BITS-1:0] sq_cell_q [0:SQRT_STAGES];
  logic                       sq_far_q  [0:SQRT_STAGES];
  logic [SUM2_W-1:0]          sq_rem_q  [0:SQRT_STAGES];
  logic [SUM2_W-1:0]          sq_res_q  [0:SQRT_STAGES];
  logic [SUM2_W-1:0]          sq_rem_d  [1:SQRT_STAGES];
  logic [SUM2_W-1:0]          sq_res_d  [1:SQRT_STAGES];

  always_comb begin
    for (int k = 0; k < SQRT_STAGES; k++) begin
      logic [SUM2_W-1:0] bitv;
      logic [SUM2_W-1:0] trial;
      bitv  = SUM2_W'(1) << (SUM2_W - 2 - 2 * k);
      trial = sq_res_q[k] + bitv;
      if (sq_rem_q[k] >= trial) begin
        sq_rem_d[k+1] = sq_rem_q[k] - trial;
        sq_res_d[k+1] = (sq_res_q[k] >> 1) + bitv;
      end else begin
        sq_rem_d[k+1] = sq_rem_q[k];
        sq_res_d[k+1] = sq_res_q[k] >> 1;
      end
    end
  end

  // ring test input
  logic [DIST_W-1:0]          rc_dist;

  assign rc_dist = sq_res_q[SQRT_STAGES][DIST_W-1:0];

  // restoring divider: entry 0 is the ring-test stage, one quotient bit per stage
  logic                       dv_vld_q  [0:DIV_STAGES];
  logic [CELL_INDEX_BITS-1:0] dv_cell_q [0:DIV_STAGES];
  logic                       dv_hit_q  [0:DIV_STAGES];
  logic                       dv_wz_q   [0:DIV_STAGES];
  logic [RAD_W-1:0]           dv_w_q    [0:DIV_STAGES];
  logic [DIST_W-1:0]          dv_r_q    [0:DIV_STAGES];
  logic [SW-1:0]              dv_quo_q  [0:DIV_STAGES];
  logic [DIST_W-1:0]          dv_r_d    [1:DIV_STAGES];
  logic [SW-1:0]              dv_quo_d  [1:DIV_STAGES];

  always_comb begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      logic [DIST_W-1:0] rt;
      // the remainder stays below the width, so doubling it fits
      rt = (j == 0) ? dv_r_q[j] : (dv_r_q[j] << 1);
      if (rt >= DIST_W'(dv_w_q[j])) begin
        dv_r_d[j+1]   = rt - DIST_W'(dv_w_q[j]);
        dv_quo_d[j+1] = {dv_quo_q[j][SW-2:0], 1'b1};
      end else begin
        dv_r_d[j+1]   = rt;
        dv_quo_d[j+1] = {dv_quo_q[j][SW-2:0], 1'b0};
      end
    end
  end

  // output register
  logic                       out_vld_q;
  logic [CELL_INDEX_BITS-1:0] out_cell_q;
  logic [SW-1:0]              out_sigma_q;
  logic [SW-1:0]              out_sigma_d;

  always_comb begin
    if (dv_wz_q[DIV_STAGES]) begin
      out_sigma_d = '0;
    end else if (dv_quo_q[DIV_STAGES] > SIGMA_ONE) begin
      out_sigma_d = SIGMA_ONE;
    end else begin
      out_sigma_d = dv_quo_q[DIV_STAGES];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      for (int k = 0; k <= SQRT_STAGES; k++) begin
        sq_vld_q[k] <= 1'b0;
      end
      for (int j = 0; j <= DIV_STAGES; j++) begin
        dv_vld_q[j] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q    <= in_valid_i;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      s4_vld_q    <= s3_vld_q;
      s5_vld_q    <= s4_vld_q;
      sq_vld_q[0] <= s5_vld_q;
      for (int k = 0; k < SQRT_STAGES; k++) begin
        sq_vld_q[k+1] <= sq_vld_q[k];
      end
      dv_vld_q[0] <= sq_vld_q[SQRT_STAGES];
      for (int j = 0; j < DIV_STAGES; j++) begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
      // misses drop out here
      out_vld_q <= dv_vld_q[DIV_STAGES] && dv_hit_q[DIV_STAGES];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cell_q <= cell_index_i;
      s1_px_q   <= point_x_i;
      s1_py_q   <= point_y_i;
      s1_pz_q   <= point_z_i;
      s1_mx_q   <= axis_x_q * point_x_i;
      s1_my_q   <= axis_y_q * point_y_i;
      s1_mz_q   <= axis_z_q * point_z_i;

      s2_cell_q <= s1_cell_q;
      s2_px_q   <= s1_px_q;
      s2_py_q   <= s1_py_q;
      s2_pz_q   <= s1_pz_q;
      s2_dot_q  <= s2_dot_full[DOT_W-1:0];

      s3_cell_q <= s2_cell_q;
      s3_px_q   <= s2_px_q;
      s3_py_q   <= s2_py_q;
      s3_pz_q   <= s2_pz_q;
      s3_mx_q   <= s2_dot_q * axis_x_q;
      s3_my_q   <= s2_dot_q * axis_y_q;
      s3_mz_q   <= s2_dot_q * axis_z_q;

      s4_cell_q <= s3_cell_q;
      s4_dx_q   <= s4_dx_d;
      s4_dy_q   <= s4_dy_d;
      s4_dz_q   <= s4_dz_d;

      s5_cell_q <= s4_cell_q;
      // a component of magnitude 2^31 or more puts the point beyond any radius
      s5_far_q  <= (|s5_ax[DIFF_W-1:MAG_W]) || (|s5_ay[DIFF_W-1:MAG_W]) ||
                   (|s5_az[DIFF_W-1:MAG_W]);
      s5_qx_q   <= s5_ax[MAG_W-1:0] * s5_ax[MAG_W-1:0];
      s5_qy_q   <= s5_ay[MAG_W-1:0] * s5_ay[MAG_W-1:0];
      s5_qz_q   <= s5_az[MAG_W-1:0] * s5_az[MAG_W-1:0];

      sq_cell_q[0] <= s5_cell_q;
      sq_far_q[0]  <= s5_far_q;
      sq_rem_q[0]  <= SUM2_W'(s5_qx_q) + SUM2_W'(s5_qy_q) + SUM2_W'(s5_qz_q);
      sq_res_q[0]  <= '0;
      for (int k = 0; k < SQRT_STAGES; k++) begin
        sq_cell_q[k+1] <= sq_cell_q[k];
        sq_far_q[k+1]  <= sq_far_q[k];
        sq_rem_q[k+1]  <= sq_rem_d[k+1];
        sq_res_q[k+1]  <= sq_res_d[k+1];
      end

      // ring test
      dv_cell_q[0] <= sq_cell_q[SQRT_STAGES];
      dv_hit_q[0]  <= !sq_far_q[SQRT_STAGES] &&
                      (rc_dist >= DIST_W'(rad_in_q)) && (rc_dist <= DIST_W'(rad_out_q));
      dv_r_q[0]    <= rc_dist - DIST_W'(rad_in_q);
      dv_w_q[0]    <= rad_out_q - rad_in_q;
      dv_wz_q[0]   <= (rad_out_q == rad_in_q);
      dv_quo_q[0]  <= '0;

      for (int j = 0; j < DIV_STAGES; j++) begin
        dv_cell_q[j+1] <= dv_cell_q[j];
        dv_hit_q[j+1]  <= dv_hit_q[j];
        dv_wz_q[j+1]   <= dv_wz_q[j];
        dv_w_q[j+1]    <= dv_w_q[j];
        dv_r_q[j+1]    <= dv_r_d[j+1];
        dv_quo_q[j+1]  <= dv_quo_d[j+1];
      end

      out_cell_q  <= dv_cell_q[DIV_STAGES];
      out_sigma_q <= out_sigma_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign zone_cell_index_o = out_cell_q;
  assign sigma_o           = out_sigma_q;

  // checks
  `AZCS_ASSERT_IMP(a_sigma_max, clk_i, rst_ni, out_valid_o, sigma_o <= SIGMA_ONE, "sigma above one")
  `AZCS_ASSERT_IMP(a_zero_width, clk_i, rst_ni, out_valid_o && (rad_in_q == rad_out_q), sigma_o == '0, "zero width sigma not zero")
  `AZCS_ASSERT_IMP(a_quot_bound, clk_i, rst_ni, dv_vld_q[DIV_STAGES] && dv_hit_q[DIV_STAGES] && !dv_wz_q[DIV_STAGES], dv_quo_q[DIV_STAGES] <= SIGMA_ONE, "quotient exceeds one")
  `AZCS_ASSERT_NXT(a_enter, clk_i, rst_ni, in_valid_i && in_ready_o, s1_vld_q, "accepted point not in first stage")

endmodule
